>>> hdl/dsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsv_pkg: shared types and constants for the DD-MM-YYYY date checker
// Character codes, string geometry, register indexes and the per-string
// accumulator record.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned VAL_W   = 7;
    localparam int unsigned COUNT_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd11;
    localparam logic [COUNT_W-1:0] DATE_LEN  = 4'd10;
    localparam logic [COUNT_W-1:0] DASH_POS0 = 4'd2;
    localparam logic [COUNT_W-1:0] DASH_POS1 = 4'd5;
    localparam logic [COUNT_W-1:0] MONTH_POS = 4'd3;
    localparam logic [COUNT_W-1:0] CENT_POS  = 4'd6;
    localparam logic [COUNT_W-1:0] YIC_POS   = 4'd8;

    localparam logic [7:0] DASH_CODE = 8'h2D;
    localparam logic [7:0] ZERO_CODE = 8'h30;
    localparam logic [7:0] NINE_CODE = 8'h39;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1900;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2100;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_YEAR = 2'd0;
    localparam logic [1:0] REG_MAX_YEAR = 2'd1;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               fmt_ok;
        logic [VAL_W-1:0]   day;
        logic [VAL_W-1:0]   month;
        logic [VAL_W-1:0]   century;
        logic [VAL_W-1:0]   yic;
    } t_str_state;

    localparam t_str_state STR_CLEAR = '{
        count:   '0,
        fmt_ok:  1'b1,
        day:     '0,
        month:   '0,
        century: '0,
        yic:     '0
    };

    // acc * 10 + d, kept to 7 bits
    function automatic logic [VAL_W-1:0] push_digit(input logic [VAL_W-1:0] acc,
                                                    input logic [3:0] d);
        logic [10:0] t;
        t = ({4'b0, acc} * 11'd10) + {7'b0, d};
        return t[VAL_W-1:0];
    endfunction

endpackage

>>> hdl/date_string_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_string_validator: DD-MM-YYYY date string checker
// Takes one ASCII character per item and gives one valid flag per string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries i_char_code and i_last_char.
//   One character is taken per clock while o_stall is low. The character
//   marked by i_last_char ends the string and produces exactly one result
//   item on the output channel (o_valid / i_stall) carrying o_date_valid;
//   other characters produce nothing.
//   The last character is captured in the judge register and then moves on
//   to the result register, which drives o_valid.
//   Throughput: one character per cycle while o_stall is low; back-to-back
//   strings of any length are fine.
//   When the receiver stalls, the result register holds and the judge
//   register still absorbs one more finished string; o_stall rises only
//   when both are full.
//   Reset (i_rst_n low, synchronous) empties the pipeline, clears the
//   string accumulator and loads the year limits with 1900 and 2100.
//   Year limits are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle; indexes other than 0 and 1 are ignored.
// ----------------------------------------------------------------------------
module date_string_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [13:0] i_cfg_data,
    // character input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_date_valid
);

    logic [dsv_pkg::YEAR_W-1:0] r_min_year;
    logic [dsv_pkg::YEAR_W-1:0] r_max_year;

    dsv_pkg::t_str_state r_str;
    dsv_pkg::t_str_state n_str;
    dsv_pkg::t_str_state r_jdg;
    logic                r_jdg_valid;
    logic                r_out_valid;
    logic                r_out_date_valid;
    logic                n_out_date_valid;

    logic in_acc;
    logic out_ready;
    logic jdg_adv;
    logic is_digit;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= dsv_pkg::MIN_YEAR_RST;
            r_max_year <= dsv_pkg::MAX_YEAR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == dsv_pkg::REG_MIN_YEAR) begin
                r_min_year <= i_cfg_data;
            end
            if (i_cfg_idx == dsv_pkg::REG_MAX_YEAR) begin
                r_max_year <= i_cfg_data;
            end
        end
    end

    // ---------------- handshake ----------------
    assign out_ready = !r_out_valid || !i_stall;
    assign jdg_adv   = r_jdg_valid && out_ready;
    assign o_stall   = r_jdg_valid && !out_ready;
    assign in_acc    = i_valid && !o_stall;

    // ---------------- per-character update ----------------
    assign is_digit = (i_char_code >= dsv_pkg::ZERO_CODE) &&
                      (i_char_code <= dsv_pkg::NINE_CODE);

    always_comb begin
        n_str = r_str;
        if (r_str.count < dsv_pkg::DATE_LEN) begin
            priority if (r_str.count == dsv_pkg::DASH_POS0 ||
                         r_str.count == dsv_pkg::DASH_POS1) begin
                if (i_char_code != dsv_pkg::DASH_CODE) begin
                    n_str.fmt_ok = 1'b0;
                end
            end else if (!is_digit) begin
                n_str.fmt_ok = 1'b0;
            end else if (r_str.count < dsv_pkg::DASH_POS0) begin
                n_str.day = dsv_pkg::push_digit(r_str.day, i_char_code[3:0]);
            end else if (r_str.count < dsv_pkg::CENT_POS &&
                         r_str.count >= dsv_pkg::MONTH_POS) begin
                n_str.month = dsv_pkg::push_digit(r_str.month, i_char_code[3:0]);
            end else if (r_str.count < dsv_pkg::YIC_POS) begin
                n_str.century = dsv_pkg::push_digit(r_str.century, i_char_code[3:0]);
            end else begin
                n_str.yic = dsv_pkg::push_digit(r_str.yic, i_char_code[3:0]);
            end
        end
        if (r_str.count < dsv_pkg::COUNT_SAT) begin
            n_str.count = r_str.count + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_str <= dsv_pkg::STR_CLEAR;
        end else if (in_acc) begin
            r_str <= i_last_char ? dsv_pkg::STR_CLEAR : n_str;
        end
    end

    // finished string waits here for judging
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jdg_valid <= 1'b0;
        end else if (in_acc && i_last_char) begin
            r_jdg_valid <= 1'b1;
        end else if (jdg_adv) begin
            r_jdg_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_char) begin
            r_jdg <= n_str;
        end
    end

    // ---------------- judge ----------------
    logic [13:0] year;
    logic        leap;
    logic [4:0]  day_max;
    logic        mon_short;

    always_comb begin
        year = (14'(r_jdg.century) * 14'd100) + 14'(r_jdg.yic);
        leap = (r_jdg.yic[1:0] == 2'b00) &&
               ((r_jdg.yic != '0) || (r_jdg.century[1:0] == 2'b00));
        mon_short = (r_jdg.month == 7'd4) || (r_jdg.month == 7'd6) ||
                    (r_jdg.month == 7'd9) || (r_jdg.month == 7'd11);
        priority if (mon_short) begin
            day_max = 5'd30;
        end else if (r_jdg.month == 7'd2) begin
            day_max = leap ? 5'd29 : 5'd28;
        end else begin
            day_max = 5'd31;
        end
        n_out_date_valid = (r_jdg.count == dsv_pkg::DATE_LEN) && r_jdg.fmt_ok &&
                           (year >= r_min_year) && (year <= r_max_year) &&
                           (r_jdg.month >= 7'd1) && (r_jdg.month <= 7'd12) &&
                           (r_jdg.day >= 7'd1) && (r_jdg.day <= {2'b0, day_max});
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_jdg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (jdg_adv) begin
            r_out_date_valid <= n_out_date_valid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_date_valid = r_out_date_valid;

`ifndef SYNTHESIS
    // a last character always lands in the judge register
    a_last_to_jdg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_char) |=> r_jdg_valid)
        else $error("finished string not captured for judging");

    // accumulator is clean after a string ends
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_char) |=> (r_str.count == '0 && r_str.fmt_ok))
        else $error("string state not cleared after last item");

    // the character count saturates
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_str.count <= dsv_pkg::COUNT_SAT)
        else $error("character count beyond saturation");

    // a judged string moves to the output whenever the output can take it
    a_jdg_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jdg_adv |=> o_valid)
        else $error("judged item lost before output");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the DD-MM-YYYY date string checker
// Streams date strings one character per item, tracks the accumulator and
// year limits in a local model, and compares every valid flag in order.
// Phases change the year limits and the idle/stall pattern on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 3;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 8;
    localparam int CHARS_PER_PH = 88;
    localparam int ACC_W        = dsv_pkg::VAL_W;

    // indexes the block ignores
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_char_item;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = dsv_pkg::REG_MIN_YEAR;
    logic [13:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_char_code = '0;
    logic        i_last_char = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_date_valid;

    date_string_validator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_date_valid (o_date_valid)
    );

    always #CLK_HALF i_clk = ~i_clk;

    t_char_item char_q[$];
    logic       valid_flag_q[$];
    t_idle_mode idle_mode = IDLE_NONE;

    int errors       = 0;
    int n_chars      = 0;
    int n_results    = 0;
    int n_good_dates = 0;
    int n_settings   = 0;
    int cycle_count  = 0;

    // local copy of the limits and the string accumulator
    logic [dsv_pkg::YEAR_W-1:0]  lim_min   = dsv_pkg::MIN_YEAR_RST;
    logic [dsv_pkg::YEAR_W-1:0]  lim_max   = dsv_pkg::MAX_YEAR_RST;
    logic [dsv_pkg::COUNT_W-1:0] acc_count = '0;
    logic                        acc_fmt   = 1'b1;
    logic [dsv_pkg::VAL_W-1:0]   acc_day   = '0;
    logic [dsv_pkg::VAL_W-1:0]   acc_month = '0;
    logic [dsv_pkg::VAL_W-1:0]   acc_cent  = '0;
    logic [dsv_pkg::VAL_W-1:0]   acc_yic   = '0;

    task automatic track_char(input logic [7:0] c, input logic last);
        logic is_dig;
        logic ok;
        logic leap;
        int   d;
        int   yr;
        int   dmax;
        is_dig = (c >= dsv_pkg::ZERO_CODE) && (c <= dsv_pkg::NINE_CODE);
        d = is_dig ? int'(c - dsv_pkg::ZERO_CODE) : 0;
        if (acc_count < dsv_pkg::DATE_LEN) begin
            if (acc_count == dsv_pkg::DASH_POS0 || acc_count == dsv_pkg::DASH_POS1) begin
                if (c != dsv_pkg::DASH_CODE) acc_fmt = 1'b0;
            end else if (!is_dig) begin
                acc_fmt = 1'b0;
            end else if (acc_count < dsv_pkg::MONTH_POS) begin
                acc_day = ACC_W'(acc_day * 10 + d);
            end else if (acc_count < dsv_pkg::CENT_POS) begin
                acc_month = ACC_W'(acc_month * 10 + d);
            end else if (acc_count < dsv_pkg::YIC_POS) begin
                acc_cent = ACC_W'(acc_cent * 10 + d);
            end else begin
                acc_yic = ACC_W'(acc_yic * 10 + d);
            end
        end
        if (acc_count < dsv_pkg::COUNT_SAT) acc_count = acc_count + 1'b1;
        if (last) begin
            ok = 1'b0;
            if (acc_count == dsv_pkg::DATE_LEN && acc_fmt) begin
                yr = acc_cent * 100 + acc_yic;
                if (yr >= lim_min && yr <= lim_max && acc_month >= 1 && acc_month <= 12
                        && acc_day >= 1 && acc_day <= 31) begin
                    // Gregorian rule: century years leap only when divisible by 400
                    leap = (acc_yic % 4 == 0) && (acc_yic != 0 || acc_cent % 4 == 0);
                    case (acc_month)
                        4, 6, 9, 11: dmax = 30;
                        2:           dmax = leap ? 29 : 28;
                        default:     dmax = 31;
                    endcase
                    ok = (acc_day <= dmax);
                end
            end
            valid_flag_q.push_back(ok);
            acc_count = '0;
            acc_fmt   = 1'b1;
            acc_day   = '0;
            acc_month = '0;
            acc_cent  = '0;
            acc_yic   = '0;
        end
    endtask

    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99, 0) < 87;
            IDLE_BOTH:   return $urandom_range(99, 0) < 10;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(99, 0) < 87;
            IDLE_BOTH:     return $urandom_range(99, 0) < 10;
            default:       return 1'b0;
        endcase
    endfunction

    // character driver
    always @(posedge i_clk) begin : drv
        t_char_item nxt;
        logic       busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                track_char(i_char_code, i_last_char);
                n_chars++;
            end
            busy = i_valid && o_stall;
            if (!busy) begin
                if (char_q.size() != 0 && !sender_gap()) begin
                    nxt = char_q.pop_front();
                    i_valid     <= 1'b1;
                    i_char_code <= nxt.code;
                    i_last_char <= nxt.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin : mon
        logic exp_flag;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (o_date_valid === 1'b1) n_good_dates++;
                if (valid_flag_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual date_valid=%0b",
                             $time, o_date_valid);
                    errors++;
                end else begin
                    exp_flag = valid_flag_q.pop_front();
                    if (o_date_valid !== exp_flag) begin
                        $display("%0t: date_valid mismatch, expected %0b, actual %0b",
                                 $time, exp_flag, o_date_valid);
                        errors++;
                    end
                end
            end
            i_stall <= receiver_stall();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("date_string_validator verification failed");
            $finish;
        end
    end

    task automatic push_char(input logic [7:0] c, input logic last);
        t_char_item it;
        it.code = c;
        it.last = last;
        char_q.push_back(it);
    endtask

    // ten characters DD-MM-YYYY, optionally with one character replaced and optionally without the end mark
    task automatic push_date(input int day, input int month, input int year,
                             input int bad_pos, input bit mark);
        logic [7:0] s [10];
        s[0] = dsv_pkg::ZERO_CODE + 8'(day / 10);
        s[1] = dsv_pkg::ZERO_CODE + 8'(day % 10);
        s[2] = dsv_pkg::DASH_CODE;
        s[3] = dsv_pkg::ZERO_CODE + 8'(month / 10);
        s[4] = dsv_pkg::ZERO_CODE + 8'(month % 10);
        s[5] = dsv_pkg::DASH_CODE;
        s[6] = dsv_pkg::ZERO_CODE + 8'(year / 1000 % 10);
        s[7] = dsv_pkg::ZERO_CODE + 8'(year / 100 % 10);
        s[8] = dsv_pkg::ZERO_CODE + 8'(year / 10 % 10);
        s[9] = dsv_pkg::ZERO_CODE + 8'(year % 10);
        if (bad_pos >= 0) s[bad_pos] = 8'($urandom_range(255, 0));
        for (int k = 0; k < 10; k++) push_char(s[k], mark && k == 9);
    endtask

    task automatic push_random_string();
        int specials [6] = '{0, 1900, 2000, 2100, 2400, 9999};
        int kind;
        int r;
        int year;
        int month;
        int day;
        int hi;
        int len;
        logic [7:0] c;
        kind = $urandom_range(99, 0);
        if (kind < 75) begin
            r = $urandom_range(9, 0);
            hi = (lim_max > 9999) ? 9999 : int'(lim_max);
            if (r < 6 && lim_min <= hi) year = $urandom_range(hi, lim_min);
            else if (r < 8)             year = specials[$urandom_range(5, 0)];
            else                        year = $urandom_range(9999, 0);
            if ($urandom_range(9, 0) < 9) month = $urandom_range(12, 1);
            else month = $urandom_range(1, 0) ? 0 : $urandom_range(99, 13);
            r = $urandom_range(9, 0);
            // bias toward month-end days so the 28/29/30/31 limits get hit
            if (r < 5)      day = $urandom_range(31, 1);
            else if (r < 8) day = $urandom_range(31, 28);
            else            day = $urandom_range(1, 0) ? 0 : $urandom_range(99, 32);
            if (kind < 60)      push_date(day, month, year, -1, 1'b1);
            else if (kind < 65) push_date(day, month, year, -1, 1'b0);  // runs into next
            else                push_date(day, month, year, $urandom_range(9, 0), 1'b1);
        end else if (kind < 87) begin
            len = $urandom_range(1, 0) ? $urandom_range(9, 1) : $urandom_range(16, 11);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(9, 0) == 0) c = 8'($urandom_range(255, 0));
                else if (k == 2 || k == 5)     c = dsv_pkg::DASH_CODE;
                else c = dsv_pkg::ZERO_CODE + 8'($urandom_range(9, 0));
                push_char(c, k == len - 1);
            end
        end else begin
            len = $urandom_range(4, 1);
            for (int k = 0; k < len; k++)
                push_char(8'($urandom_range(255, 0)), k == len - 1 && $urandom_range(1, 0));
        end
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [13:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == dsv_pkg::REG_MIN_YEAR)      lim_min = data;
        else if (idx == dsv_pkg::REG_MAX_YEAR) lim_max = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (char_q.size() != 0 || i_valid || valid_flag_q.size() != 0);
    endtask

    initial begin : stim
        int         phase_min [PHASES] = '{0, 2000, 2100, 0, -1, 16383, 1900, 0};
        int         phase_max [PHASES] = '{9999, 2000, 1900, 16383, -1, 16383, 2100, 0};
        t_idle_mode phase_mode [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                            IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        int lo;
        int hi;
        int tmp;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: leap day under reset limits, zero and all-ones codes,
        // a string with no end mark running into an over-long one
        @(negedge i_clk);
        push_date(29, 2, 2000, -1, 1'b1);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b1);
        push_date(31, 12, 2100, -1, 1'b0);
        push_char(dsv_pkg::ZERO_CODE + 8'd7, 1'b0);
        push_char(dsv_pkg::ZERO_CODE + 8'd7, 1'b1);
        n_settings++;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (phase_min[p] < 0) begin
                lo = $urandom_range(9999, 0);
                hi = $urandom_range(9999, 0);
                if (lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end else begin
                lo = phase_min[p];
                hi = phase_max[p];
            end
            write_cfg(dsv_pkg::REG_MIN_YEAR, 14'(lo));
            write_cfg(dsv_pkg::REG_MAX_YEAR, 14'(hi));
            if (p == 5) begin
                write_cfg(REG_SPARE_2, 14'($urandom_range(16383, 0)));
                write_cfg(REG_SPARE_3, 14'($urandom_range(16383, 0)));
            end
            n_settings++;
            @(negedge i_clk);
            idle_mode = phase_mode[p];
            tmp = char_q.size();
            while (char_q.size() - tmp < CHARS_PER_PH) push_random_string();
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (valid_flag_q.size() != 0) begin
            $display("%0t: %0d results still expected, actual none", $time,
                     valid_flag_q.size());
            errors++;
        end
        $display("run: %0d characters, %0d strings judged, %0d accepted as dates",
                 n_chars, n_results, n_good_dates);
        $display("run: %0d year-limit settings, four idle patterns, %0d errors",
                 n_settings, errors);
        if (errors == 0) begin
            $display("date_string_validator verification clean");
        end else begin
            $display("date_string_validator verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/dsv_pkg.sv
hdl/date_string_validator.sv
tb/sv/tb_top.sv
